// ===== rtl/skrt_pkg.sv =====
// Shared types and constants of the sorted key rank table.
`timescale 1ns / 1ps
`default_nettype none
package skrt_pkg;

  // Default number of cells in the chain.
  localparam int unsigned CapacityDefault = 64;

  // Field widths of one record and of the command stream.
  localparam int unsigned KeyW    = 64;
  localparam int unsigned HandleW = 32;
  localparam int unsigned KindW   = 8;
  localparam int unsigned RankW   = 6;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned OutCntW = 7;

  // Packed widths of the stream data words.
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 120;

  // Command codes carried in the input tuser.
  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

  // One stored hit record.
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [HandleW-1:0]     handle;
    logic [KindW-1:0]       kind;
  } entry_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic   insert_en;
    logic   read_en;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/skrt_cell.sv =====
// One cell of the sorted chain: holds one record and a slot of the read bus.
`timescale 1ns / 1ps
`default_nettype none
module skrt_cell (
  input  wire                  clk_i,
  input  var skrt_pkg::cell_ctrl_t ctrl_i,
  input  wire                  in_use_i,    // This cell holds a live record.
  input  wire                  read_sel_i,  // This cell sits at the requested rank.
  input  wire                  left_less_i, // Left neighbor keeps its record.
  input  var skrt_pkg::entry_t left_entry_i,
  input  var skrt_pkg::entry_t left_rd_i,
  output logic                 less_o,
  output skrt_pkg::entry_t     entry_o,
  output skrt_pkg::entry_t     rd_o
);

  skrt_pkg::entry_t entry_q, entry_d;
  skrt_pkg::entry_t rd_q, rd_d;

  // A live record with a strictly smaller key stays in place.
  assign less_o = in_use_i && (entry_q.key < ctrl_i.new_entry.key);

  // On insert the cell keeps its record, takes the new one, or takes its left neighbor's.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert_en && !less_o) begin
      entry_d = left_less_i ? ctrl_i.new_entry : left_entry_i;
    end
  end

  // Read bus: the selected cell drops its record in, the others pass theirs right.
  always_comb begin
    rd_d = rd_q;
    if (ctrl_i.read_en) begin
      rd_d = read_sel_i ? entry_q : left_rd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rd_q    <= rd_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule
`default_nettype wire

// ===== rtl/sorted_key_rank_table.sv =====
// Top level of the sorted key rank table: cell chain, count and command sequencer.
//
//  Channel  Dir  Handshake              Payload
//  s_axis   in   tvalid/tready          tuser: cmd; tdata: key, handle, kind, rank
//  m_axis   out  tvalid/tready          tdata: found, key, handle, kind, count, refused
//
// An insert, clear or unused command loads its result into the output register at its transfer.
// A get shifts the registered read bus in ST_READ once per cell to carry the record on to
// the last cell of the chain, and ST_DONE then loads the output register once it is free.
// A new command is taken in the idle state once the output register is free or being drained.
// Reset empties the table at once; the record storage itself is not cleared.
// A stalled output holds its result and blocks further input.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_rank_table #(
  parameter int unsigned CAPACITY = skrt_pkg::CapacityDefault
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: key_value[63:0], object_handle[95:64], object_kind[103:96],
  // rank[109:104], zero fill[111:110].
  input  wire [skrt_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser from bit 0: cmd[1:0].
  input  wire [skrt_pkg::CmdW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // tdata from bit 0: entry_found[0], found_key[64:1], found_handle[96:65],
  // found_kind[104:97], stored_count[111:105], insert_refused[112], zero fill[119:113].
  output logic [skrt_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CntW > skrt_pkg::RankW) ? CntW : skrt_pkg::RankW;

  // Unpack the input transfer.
  skrt_pkg::cmd_e              in_cmd;
  skrt_pkg::entry_t            in_entry;
  logic [skrt_pkg::RankW-1:0]  in_rank;

  assign in_cmd          = skrt_pkg::cmd_e'(s_axis_tuser);
  assign in_entry.key    = s_axis_tdata[63:0];
  assign in_entry.handle = s_axis_tdata[95:64];
  assign in_entry.kind   = s_axis_tdata[103:96];
  assign in_rank         = s_axis_tdata[109:104];

  // Control and result state.
  skrt_pkg::state_e            state_q, state_d;
  logic [CntW-1:0]             count_q, count_d;
  logic [IdxW-1:0]             cnt_q, cnt_d;
  logic [skrt_pkg::RankW-1:0]  rank_q, rank_d;
  logic                        found_q, found_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_found_q, out_found_d;
  skrt_pkg::entry_t            out_entry_q, out_entry_d;
  logic [skrt_pkg::OutCntW-1:0] out_count_q, out_count_d;
  logic                        out_refused_q, out_refused_d;
  skrt_pkg::cell_ctrl_t        ctrl;

  // Chain links.
  logic                        less_w  [CAPACITY];
  skrt_pkg::entry_t            entry_w [CAPACITY];
  skrt_pkg::entry_t            rd_w    [CAPACITY];

  logic accept;
  logic out_free;
  logic full;
  logic rank_hit;

  assign out_free = !out_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign full     = (count_q == CntW'(CAPACITY));
  assign rank_hit = (CmpW'(in_rank) < CmpW'(count_q));

  // Cell chain.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             in_use;
    logic             read_sel;
    logic             left_less;
    skrt_pkg::entry_t left_entry;
    skrt_pkg::entry_t left_rd;

    assign in_use   = (CntW'(i) < count_q);
    assign read_sel = (CmpW'(rank_q) == CmpW'(i));

    if (i == 0) begin : g_head
      assign left_less  = 1'b1;
      assign left_entry = '0;
      assign left_rd    = '0;
    end else begin : g_body
      assign left_less  = less_w[i-1];
      assign left_entry = entry_w[i-1];
      assign left_rd    = rd_w[i-1];
    end

    skrt_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .in_use_i     (in_use),
      .read_sel_i   (read_sel),
      .left_less_i  (left_less),
      .left_entry_i (left_entry),
      .left_rd_i    (left_rd),
      .less_o       (less_w[i]),
      .entry_o      (entry_w[i]),
      .rd_o         (rd_w[i])
    );
  end

  // Sequencer: next state, chain controls and output register loads.
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    cnt_d          = cnt_q;
    rank_d         = rank_q;
    found_d        = found_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_found_d    = out_found_q;
    out_entry_d    = out_entry_q;
    out_count_d    = out_count_q;
    out_refused_d  = out_refused_q;
    s_axis_tready  = 1'b0;
    ctrl.insert_en = 1'b0;
    ctrl.read_en   = 1'b0;
    ctrl.new_entry = in_entry;

    unique case (state_q)
      skrt_pkg::ST_IDLE: begin
        s_axis_tready = out_free;
        if (accept) begin
          unique case (in_cmd)
            skrt_pkg::CMD_INSERT: begin
              ctrl.insert_en = !full;
              if (!full) begin
                count_d = count_q + CntW'(1);
              end
              out_valid_d   = 1'b1;
              out_found_d   = 1'b0;
              out_entry_d   = '0;
              out_count_d   = skrt_pkg::OutCntW'(full ? count_q : count_q + CntW'(1));
              out_refused_d = full;
            end
            skrt_pkg::CMD_GET: begin
              rank_d  = in_rank;
              found_d = rank_hit;
              cnt_d   = '0;
              state_d = skrt_pkg::ST_READ;
            end
            skrt_pkg::CMD_CLEAR: begin
              count_d       = '0;
              out_valid_d   = 1'b1;
              out_found_d   = 1'b0;
              out_entry_d   = '0;
              out_count_d   = '0;
              out_refused_d = 1'b0;
            end
            default: begin
              out_valid_d   = 1'b1;
              out_found_d   = 1'b0;
              out_entry_d   = '0;
              out_count_d   = skrt_pkg::OutCntW'(count_q);
              out_refused_d = 1'b0;
            end
          endcase
        end
      end
      skrt_pkg::ST_READ: begin
        // The read bus shifts once per cell.
        ctrl.read_en = 1'b1;
        cnt_d        = cnt_q + IdxW'(1);
        if (cnt_q == IdxW'(CAPACITY - 1)) begin
          state_d = skrt_pkg::ST_DONE;
        end
      end
      skrt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_found_d   = found_q;
          out_entry_d   = found_q ? rd_w[CAPACITY-1] : '0;
          out_count_d   = skrt_pkg::OutCntW'(count_q);
          out_refused_d = 1'b0;
          state_d       = skrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = skrt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skrt_pkg::ST_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rank_q        <= rank_d;
    found_q       <= found_d;
    out_found_q   <= out_found_d;
    out_entry_q   <= out_entry_d;
    out_count_q   <= out_count_d;
    out_refused_q <= out_refused_d;
  end

  // Pack the output transfer.
  assign m_axis_tvalid         = out_valid_q;
  assign m_axis_tdata[0]       = out_found_q;
  assign m_axis_tdata[64:1]    = out_entry_q.key;
  assign m_axis_tdata[96:65]   = out_entry_q.handle;
  assign m_axis_tdata[104:97]  = out_entry_q.kind;
  assign m_axis_tdata[111:105] = out_count_q;
  assign m_axis_tdata[112]     = out_refused_q;
  assign m_axis_tdata[119:113] = '0;

endmodule
`default_nettype wire

// ===== sim/sorted_key_rank_table_monitor.sv =====
// Checker that predicts every reply of the rank table and compares it with the output stream.
`timescale 1ns / 1ps
module sorted_key_rank_table_monitor
  import skrt_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid_i,
  input  wire                 s_axis_tready_i,
  // tdata from bit 0: key_value, object_handle, object_kind, rank, zero fill.
  input  wire [InDataW-1:0]   s_axis_tdata_i,
  // tuser from bit 0: cmd.
  input  wire [CmdW-1:0]      s_axis_tuser_i,
  input  wire                 m_axis_tvalid_i,
  input  wire                 m_axis_tready_i,
  // tdata from bit 0: entry_found, found_key, found_handle, found_kind,
  // stored_count, insert_refused, zero fill.
  input  wire [OutDataW-1:0]  m_axis_tdata_i,
  output int unsigned         pending_o,
  output int unsigned         mismatch_count_o
);

  // One reply of the table, as it is expected on the output stream.
  typedef struct packed {
    logic                   found;
    logic signed [KeyW-1:0] key;
    logic [HandleW-1:0]     handle;
    logic [KindW-1:0]       kind;
    logic [OutCntW-1:0]     count;
    logic                   refused;
  } table_reply_t;

  // Own copy of the sorted table.
  logic signed [KeyW-1:0] tbl_key    [CAPACITY];
  logic [HandleW-1:0]     tbl_handle [CAPACITY];
  logic [KindW-1:0]       tbl_kind   [CAPACITY];
  int unsigned            tbl_fill;

  // Replies still owed by the block, oldest first.
  table_reply_t reply_q[$];

  // Applies one command to the table copy and returns the reply it causes.
  function automatic table_reply_t apply_command(cmd_e cmd, logic signed [KeyW-1:0] key,
                                                 logic [HandleW-1:0] handle,
                                                 logic [KindW-1:0] kind,
                                                 logic [RankW-1:0] rank);
    table_reply_t reply;
    int unsigned  slot;
    int unsigned  i;
    reply = '0;
    case (cmd)
      CMD_INSERT: begin
        if (tbl_fill >= CAPACITY) begin
          reply.refused = 1'b1;
        end else begin
          // The new record goes after every strictly smaller key, so ahead of equal keys.
          slot = 0;
          while (slot < tbl_fill && tbl_key[slot] < key) slot++;
          for (i = tbl_fill; i > slot; i--) begin
            tbl_key[i]    = tbl_key[i-1];
            tbl_handle[i] = tbl_handle[i-1];
            tbl_kind[i]   = tbl_kind[i-1];
          end
          tbl_key[slot]    = key;
          tbl_handle[slot] = handle;
          tbl_kind[slot]   = kind;
          tbl_fill++;
        end
      end
      CMD_GET: begin
        if (rank < tbl_fill) begin
          reply.found  = 1'b1;
          reply.key    = tbl_key[rank];
          reply.handle = tbl_handle[rank];
          reply.kind   = tbl_kind[rank];
        end
      end
      CMD_CLEAR: begin
        tbl_fill = 0;
      end
      default: begin
      end
    endcase
    reply.count = tbl_fill[OutCntW-1:0];
    return reply;
  endfunction

  // Compares one field of a reply and reports a difference.
  task automatic check_field(string name, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  // Replies leave before new commands enter: a command never answers in its own cycle.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_reply_t want;
    if (!rst_ni) begin
      tbl_fill = 0;
      reply_q.delete();
      pending_o = 0;
      mismatch_count_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected reply %h", $time, m_axis_tdata_i);
          mismatch_count_o++;
        end else begin
          want = reply_q.pop_front();
          check_field("entry_found", 64'(want.found), 64'(m_axis_tdata_i[0]));
          check_field("found_key", want.key, m_axis_tdata_i[64:1]);
          check_field("found_handle", 64'(want.handle), 64'(m_axis_tdata_i[96:65]));
          check_field("found_kind", 64'(want.kind), 64'(m_axis_tdata_i[104:97]));
          check_field("stored_count", 64'(want.count), 64'(m_axis_tdata_i[111:105]));
          check_field("insert_refused", 64'(want.refused), 64'(m_axis_tdata_i[112]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        reply_q.push_back(apply_command(cmd_e'(s_axis_tuser_i), s_axis_tdata_i[63:0],
                                        s_axis_tdata_i[95:64], s_axis_tdata_i[103:96],
                                        s_axis_tdata_i[109:104]));
      end
      pending_o = reply_q.size();
    end
  end

endmodule

// ===== sim/sorted_key_rank_table_tb.sv =====
// Testbench top of the sorted key rank table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module sorted_key_rank_table_tb;
  import skrt_pkg::*;

  localparam int unsigned Capacity    = CapacityDefault;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam logic [KeyW-1:0] MaxKey  = {1'b0, {(KeyW-1){1'b1}}};
  localparam logic [KeyW-1:0] MinKey  = {1'b1, {(KeyW-1){1'b0}}};

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic [CmdW-1:0]     s_tuser  = CMD_NONE;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  // Set for stretches in which neither side pauses.
  logic        quiet        = 1'b0;
  int unsigned ready_left   = 0;
  int unsigned cycle_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned fill_est     = 0;
  int unsigned pending;
  int unsigned mismatches;

  always #4 clk_i = ~clk_i;

  sorted_key_rank_table #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  sorted_key_rank_table_monitor #(
    .CAPACITY(Capacity)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .pending_o       (pending),
    .mismatch_count_o(mismatches)
  );

  // Pause length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  // Keys: extremes, a narrow band around zero for ties, and full random patterns.
  function automatic logic [KeyW-1:0] rand_key();
    int v;
    v = $urandom_range(0, 16);
    v = v - 8;
    case ($urandom_range(0, 9))
      0: return MaxKey;
      1: return MinKey;
      2, 3, 4: return 64'(v);
      5: return {32'(v), 32'($urandom_range(0, 1) << 31)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Ranks mostly inside the filled part, sometimes anywhere.
  function automatic logic [RankW-1:0] next_rank();
    if (fill_est != 0 && $urandom_range(0, 3) != 0) return RankW'($urandom_range(0, fill_est));
    return RankW'($urandom);
  endfunction

  // Presents one command and returns at the edge where it transfers.
  task automatic send_item(cmd_e cmd, logic [KeyW-1:0] key, logic [HandleW-1:0] handle,
                           logic [KindW-1:0] kind, logic [RankW-1:0] rank);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    // Two zero fill bits above the rank.
    s_tdata  <= {2'b00, rank, kind, handle, key};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (cmd == CMD_INSERT && fill_est < Capacity) fill_est++;
    if (cmd == CMD_CLEAR) fill_est = 0;
    if (cmd != CMD_NONE) items_sent++;
  endtask

  // Random command of the given code with random content.
  task automatic send_random(cmd_e cmd);
    send_item(cmd, rand_key(), $urandom, KindW'($urandom), next_rank());
  endtask

  // Holds the input idle until every reply has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Output side: alternating accept stretches and stalls.
  always @(posedge clk_i) begin : ready_gen
    int unsigned stall;
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (quiet) begin
      m_tready   <= 1'b1;
      ready_left <= 8;
    end else if (m_tready) begin
      stall = gap_len();
      if (stall == 0) begin
        ready_left <= $urandom_range(0, 10);
      end else begin
        m_tready   <= 1'b0;
        ready_left <= stall - 1;
      end
    end else begin
      m_tready   <= 1'b1;
      ready_left <= $urandom_range(0, 10);
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned rk;
    int unsigned phase;
    int unsigned pick;
    int unsigned n;
    int unsigned roll;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, unused code, extremes, ties, ranks in and out of range, clear.
    send_item(CMD_GET, '0, '0, '0, '0);
    send_item(CMD_NONE, '1, '1, '1, '1);
    send_item(CMD_INSERT, 64'd0, 32'h0000_0001, 8'h01, '0);
    send_item(CMD_INSERT, MaxKey, '1, '1, '1);
    send_item(CMD_INSERT, MinKey, '0, '0, '0);
    send_item(CMD_INSERT, '1, 32'h0000_0004, 8'h04, '0);
    // Equal key lands in front of the stored zero key.
    send_item(CMD_INSERT, 64'd0, 32'h0000_0005, 8'h05, '0);
    send_item(CMD_INSERT, 64'h0000_0001_0000_0000, 32'h0000_0006, 8'h06, '0);
    for (rk = 0; rk < 8; rk++) send_item(CMD_GET, rand_key(), $urandom, KindW'($urandom),
                                         RankW'(rk));
    send_item(CMD_GET, '0, '0, '0, '1);
    send_item(CMD_CLEAR, rand_key(), $urandom, KindW'($urandom), RankW'($urandom));
    send_item(CMD_GET, '0, '0, '0, '0);
    send_random(CMD_INSERT);
    send_item(CMD_GET, '0, '0, '0, '0);
    wait_drained();

    // Random phases: fill runs that overflow the table, mixed traffic and full rank sweeps.
    items_sent = 0;
    phase = 0;
    while (items_sent < RandomItems) begin
      quiet <= ($urandom_range(0, 5) == 0);
      pick = (phase == 0) ? 0 : $urandom_range(0, 9);
      if (pick < 3) begin
        if (phase == 0 || $urandom_range(0, 1) == 0) send_random(CMD_CLEAR);
        n = (phase == 0) ? 70 : $urandom_range(40, 72);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) send_random(CMD_GET);
          else send_random(CMD_INSERT);
        end
      end else if (pick < 8) begin
        n = $urandom_range(8, 40);
        repeat (n) begin
          roll = $urandom_range(0, 99);
          if (roll < 45) send_random(CMD_INSERT);
          else if (roll < 85) send_random(CMD_GET);
          else if (roll < 90) send_random(CMD_CLEAR);
          else send_random(CMD_NONE);
        end
      end else begin
        for (rk = 0; rk < Capacity; rk++) send_item(CMD_GET, rand_key(), $urandom,
                                                    KindW'($urandom), RankW'(rk));
      end
      if (phase == 0 || $urandom_range(0, 3) == 0) wait_drained();
      phase++;
    end

    // Drain, then leave room for any stray reply.
    wait_drained();
    repeat (2 * Capacity + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/skrt_pkg.sv
rtl/skrt_cell.sv
rtl/sorted_key_rank_table.sv
sim/sorted_key_rank_table_monitor.sv
sim/sorted_key_rank_table_tb.sv
